// ===== rtl/core/lbsr_pkg.sv =====
// Shared types, opcodes and constants of the LED beam and scroll register unit.
package lbsr_pkg;

	localparam int LINES_PER_PAGE = 256;
	localparam int SCROLL_PAGES   = 3;
	localparam int STORE_DEPTH    = SCROLL_PAGES * LINES_PER_PAGE;
	localparam int STORE_AW       = $clog2(STORE_DEPTH);
	localparam int LINE_W         = $clog2(LINES_PER_PAGE);

	localparam logic [2:0] OP_PALETTE = 3'd0;
	localparam logic [2:0] OP_SCROLL  = 3'd1;
	localparam logic [2:0] OP_SPEED   = 3'd2;
	localparam logic [2:0] OP_TRIGGER = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;
	localparam logic [2:0] OP_TICK    = 3'd5;

	localparam logic [7:0] SHOT_LEVEL_A = 8'h8b;
	localparam logic [7:0] SHOT_LEVEL_B = 8'hca;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [10:0] address;
		logic [7:0]  write_data;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  beam_position;
		logic        shot_standby;
		logic        shot_arrive;
		logic [7:0]  page_d_line;
		logic [7:0]  page_e_line;
		logic [7:0]  page_f_line;
		logic [1:0]  palette_choice;
		logic [3:0]  beam_speed;
		logic [15:0] frame_count;
	} out_word_t;

	// floor(falling-edge count * 19 / 8), count 0..4
	function automatic logic [3:0] speed_of(input logic [7:0] data);
		logic [7:0] edges;
		logic [3:0] cnt;
		edges = data & ~{data[0], data[7:1]};
		cnt = 4'($countones(edges));
		case (cnt)
			4'd0:    speed_of = 4'd0;
			4'd1:    speed_of = 4'd2;
			4'd2:    speed_of = 4'd4;
			4'd3:    speed_of = 4'd7;
			default: speed_of = 4'd9;
		endcase
	endfunction

endpackage

// ===== rtl/core/led_beam_and_scroll_register_unit.sv =====
// Top level of the LED beam sequencer and scroll offset latch unit.
module led_beam_and_scroll_register_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lbsr_pkg::in_word_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output lbsr_pkg::out_word_t out_data
);
	// One word in, one status word out, one word per cycle sustained unless
	// the output stalls or the store is being cleared. A word is accepted and
	// its scroll byte is read from the store in the same cycle; stage 1 then
	// compares, writes back and updates all the beam, flag and offset
	// registers, and the status snapshot lands in the output register, once
	// that register can take it. The single-port-write scroll store sets the
	// rate: one read-modify-write per word, with the byte being written
	// forwarded to a following word on the same line. After reset the store's
	// 768 bytes are zeroed one byte per cycle and in_ready stays low till done.
	// The output register lets a new word in while the last result is taken.

	import lbsr_pkg::*;

	// scroll byte store
	logic [7:0] store_mem [STORE_DEPTH];

	// clearing pass
	logic                clr_q;
	logic [STORE_AW-1:0] clr_idx_q;

	// stage 1
	logic               valid_s1;
	in_word_t           word_s1;
	logic [7:0]         rd_s1;
	logic               fwd_s1;
	logic [7:0]         fwd_data_s1;

	// architectural state
	logic [7:0]  line_d_q, line_e_q, line_f_q;
	logic [1:0]  palette_q;
	logic [3:0]  speed_q;
	logic [7:0]  beam_q;
	logic        standby_q;
	logic        arrive_q;
	logic [15:0] ticks_q;

	// output register
	logic      out_valid_q;
	out_word_t out_q;

	logic                in_fire, s1_fire;
	logic [STORE_AW-1:0] rd_idx;
	logic                page_ok_s1, changed_s1;
	logic [7:0]          old_byte_s1;
	logic                mem_we;
	logic [STORE_AW-1:0] mem_wa, scroll_wa;
	logic [7:0]          mem_wd;

	logic [7:0]  line_d_d, line_e_d, line_f_d;
	logic [1:0]  palette_d;
	logic [3:0]  speed_d;
	logic [7:0]  beam_d;
	logic        standby_d;
	logic        arrive_d;
	logic [15:0] ticks_d;
	logic [8:0]  pos;

	assign s1_fire  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !clr_q && (!valid_s1 || s1_fire);
	assign in_fire  = in_valid && in_ready;

	// pages 4..6 map to rows 0..2 of the store
	assign rd_idx = {in_data.address[9:8], in_data.address[LINE_W-1:0]};

	assign page_ok_s1  = word_s1.address[10] && (word_s1.address[9:8] != 2'b11);
	assign scroll_wa   = {word_s1.address[9:8], word_s1.address[LINE_W-1:0]};
	assign old_byte_s1 = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign changed_s1  = (word_s1.opcode == OP_SCROLL) && page_ok_s1
		&& (old_byte_s1 != word_s1.write_data);

	always_comb begin
		if (clr_q) begin
			mem_we = 1'b1;
			mem_wa = clr_idx_q;
			mem_wd = '0;
		end else begin
			mem_we = s1_fire && changed_s1;
			mem_wa = scroll_wa;
			mem_wd = word_s1.write_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_s1       <= store_mem[rd_idx];
			word_s1     <= in_data;
			// byte written this cycle is newer than what the store returns
			fwd_s1      <= mem_we && (mem_wa == rd_idx);
			fwd_data_s1 <= mem_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == STORE_AW'(STORE_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// next state of the register file for the word in stage 1
	always_comb begin
		line_d_d  = line_d_q;
		line_e_d  = line_e_q;
		line_f_d  = line_f_q;
		palette_d = palette_q;
		speed_d   = speed_q;
		beam_d    = beam_q;
		standby_d = standby_q;
		arrive_d  = arrive_q;
		ticks_d   = ticks_q;
		pos       = {1'b0, beam_q};
		case (word_s1.opcode)
			OP_PALETTE: begin
				if (word_s1.address == 11'd0) begin
					palette_d[0] = word_s1.write_data[0];
				end else if (word_s1.address == 11'd1) begin
					palette_d[1] = word_s1.write_data[0];
				end
			end
			OP_SCROLL: begin
				if (changed_s1 && word_s1.write_data[0]) begin
					case (word_s1.address[9:8])
						2'b00:   line_d_d = word_s1.address[7:0];
						2'b01:   line_e_d = word_s1.address[7:0];
						default: line_f_d = word_s1.address[7:0];
					endcase
				end
			end
			OP_SPEED:   speed_d = speed_of(word_s1.write_data);
			OP_TRIGGER: standby_d = 1'b0;
			OP_CLEAR:   arrive_d = 1'b0;
			OP_TICK: begin
				if (!standby_q) begin
					pos = {1'b0, beam_q} + {5'd0, speed_q};
				end
				if ((beam_q < SHOT_LEVEL_A) && (pos >= {1'b0, SHOT_LEVEL_A})) begin
					arrive_d = 1'b1;
				end
				if ((beam_q < SHOT_LEVEL_B) && (pos >= {1'b0, SHOT_LEVEL_B})) begin
					arrive_d = 1'b1;
				end
				if (pos[8]) begin
					beam_d    = '0;
					standby_d = 1'b1;
				end else begin
					beam_d = pos[7:0];
				end
				ticks_d = ticks_q + 16'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			line_d_q  <= '0;
			line_e_q  <= '0;
			line_f_q  <= '0;
			palette_q <= '0;
			speed_q   <= '0;
			beam_q    <= '0;
			standby_q <= 1'b1;
			arrive_q  <= 1'b0;
			ticks_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				line_d_q  <= line_d_d;
				line_e_q  <= line_e_d;
				line_f_q  <= line_f_d;
				palette_q <= palette_d;
				speed_q   <= speed_d;
				beam_q    <= beam_d;
				standby_q <= standby_d;
				arrive_q  <= arrive_d;
				ticks_q   <= ticks_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_q.beam_position  <= beam_d;
			out_q.shot_standby   <= standby_d;
			out_q.shot_arrive    <= arrive_d;
			out_q.page_d_line    <= line_d_d;
			out_q.page_e_line    <= line_e_d;
			out_q.page_f_line    <= line_f_d;
			out_q.palette_choice <= palette_d;
			out_q.beam_speed     <= speed_d;
			out_q.frame_count    <= ticks_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
